// ===== rtl/khi_pkg.sv =====
// karaoke highlight interpolator: shared constants, types and helpers
// no dependencies; used by every other file of the block except khi_ram
`timescale 1ns / 1ps
`default_nettype none

package khi_pkg;

  localparam int MaxBp       = 64;
  localparam int TimeBits    = 24;
  localparam int IndexBits   = 10;
  localparam int AddrBits    = $clog2(MaxBp);
  localparam int CountBits   = AddrBits + 1;
  localparam int EntryBits   = TimeBits + IndexBits;
  localparam int BitCntBits  = $clog2(IndexBits);
  localparam int QDepth      = 2;
  localparam int QPtrBits    = $clog2(QDepth);
  localparam int QCntBits    = $clog2(QDepth + 1);
  localparam int ApbAddrBits = 3;
  localparam int ApbDataBits = 32;

  // input action codes
  localparam logic [1:0] ActAppend = 2'd0;
  localparam logic [1:0] ActClear  = 2'd1;
  localparam logic [1:0] ActQuery  = 2'd2;

  // register index, taken from paddr[2]
  localparam logic RegTiming  = 1'b0;
  localparam logic RegTextLen = 1'b1;

  typedef enum logic [1:0] {
    OP_APPEND,
    OP_CLEAR,
    OP_QUERY
  } khi_op_e;

  typedef struct packed {
    khi_op_e                op;
    logic [TimeBits-1:0]    key;
    logic [IndexBits-1:0]   chr;
  } khi_cmd_t;

  typedef struct packed {
    logic                   busy;
    logic [CountBits-1:0]   bp_count;
  } khi_stat_t;

  // flip the sign bit so signed times order as unsigned keys
  function automatic logic [TimeBits-1:0] order_key(input logic [TimeBits-1:0] t);
    return t ^ {1'b1, {(TimeBits-1){1'b0}}};
  endfunction

endpackage

`default_nettype wire

// ===== rtl/khi_if.sv =====
// karaoke highlight interpolator: item and result channel interfaces
// depends on khi_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface khi_in_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          action;
  logic signed [khi_pkg::TimeBits-1:0] offset_ms;
  logic [khi_pkg::IndexBits-1:0]       char_index;

  modport source (output valid, action, offset_ms, char_index, input ready);
  modport sink   (input valid, action, offset_ms, char_index, output ready);
endinterface

interface khi_out_if;
  logic                          valid;
  logic                          ready;
  logic [khi_pkg::IndexBits-1:0] lit_count;

  modport source (output valid, lit_count, input ready);
  modport sink   (input valid, lit_count, output ready);
endinterface

`default_nettype wire

// ===== rtl/khi_ram.sv =====
// karaoke highlight interpolator: generic one-write one-read ram
// registered read data; no dependencies
`timescale 1ns / 1ps
`default_nettype none

module khi_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== rtl/khi_front.sv =====
// karaoke highlight interpolator: front end, decodes actions into commands
// and buffers them in a two-entry queue; depends on khi_pkg and khi_if
`timescale 1ns / 1ps
`default_nettype none

module khi_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  khi_in_if.sink             item_i,
  output khi_pkg::khi_cmd_t  cmd_o,
  output logic               cmd_valid_o,
  input  wire logic          cmd_ready_i
);

  khi_pkg::khi_cmd_t                   q_mem_q [khi_pkg::QDepth];
  logic [khi_pkg::QPtrBits-1:0]        wr_ptr_q, wr_ptr_d;
  logic [khi_pkg::QPtrBits-1:0]        rd_ptr_q, rd_ptr_d;
  logic [khi_pkg::QCntBits-1:0]        cnt_q, cnt_d;
  khi_pkg::khi_cmd_t                   dec_cmd;
  logic                                dec_keep;
  logic                                accept;
  logic                                push;
  logic                                pop;

  assign item_i.ready = (cnt_q != khi_pkg::QCntBits'(khi_pkg::QDepth));
  assign accept       = item_i.valid && item_i.ready;

  always_comb begin
    dec_cmd.key = khi_pkg::order_key(item_i.offset_ms);
    dec_cmd.chr = item_i.char_index;
    dec_cmd.op  = khi_pkg::OP_APPEND;
    dec_keep    = 1'b1;
    unique case (item_i.action)
      khi_pkg::ActAppend: dec_cmd.op = khi_pkg::OP_APPEND;
      khi_pkg::ActClear:  dec_cmd.op = khi_pkg::OP_CLEAR;
      khi_pkg::ActQuery:  dec_cmd.op = khi_pkg::OP_QUERY;
      // unused code: word taken and dropped
      default:            dec_keep   = 1'b0;
    endcase
  end

  assign push        = accept && dec_keep;
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = q_mem_q[rd_ptr_q];
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= dec_cmd;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/khi_back.sv =====
// karaoke highlight interpolator: back end, breakpoint store, pair scan,
// serial ceiling division and result register; depends on khi_pkg, khi_if, khi_ram
`timescale 1ns / 1ps
`default_nettype none

module khi_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire khi_pkg::khi_cmd_t             cmd_i,
  input  wire logic                          cmd_valid_i,
  output logic                               cmd_ready_o,
  input  wire logic                          timing_en_i,
  input  wire logic [khi_pkg::IndexBits-1:0] text_len_i,
  khi_out_if.source                          result_o,
  output khi_pkg::khi_stat_t                 stat_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_SUM  = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  localparam int TB = khi_pkg::TimeBits;
  localparam int IB = khi_pkg::IndexBits;

  logic [2:0]                         state_q, state_d;
  logic [khi_pkg::CountBits-1:0]      count_q, count_d;
  logic [khi_pkg::AddrBits-1:0]       idx_q, idx_d;
  logic [khi_pkg::BitCntBits-1:0]     bit_q, bit_d;
  logic                               out_valid_q, out_valid_d;

  logic [TB-1:0]                      pos_q, pos_d;
  logic [TB-1:0]                      prev_key_q, prev_key_d;
  logic [IB-1:0]                      prev_chr_q, prev_chr_d;
  logic [IB-1:0]                      c_q, c_d;
  logic [TB-1:0]                      n_q, n_d;
  logic [TB-1:0]                      d_q, d_d;
  logic [IB-1:0]                      si_q, si_d;
  logic [IB-1:0]                      quo_q, quo_d;
  logic [TB-1:0]                      rem_q, rem_d;
  logic [IB-1:0]                      res_q, res_d;
  logic [IB-1:0]                      out_data_q, out_data_d;

  logic                               ram_we;
  logic [khi_pkg::AddrBits-1:0]       ram_raddr;
  logic [khi_pkg::EntryBits-1:0]      ram_rdata;
  logic [TB-1:0]                      cur_key;
  logic [IB-1:0]                      cur_chr;
  logic                               cmd_fire;
  logic                               hit;

  logic [TB+1:0]                      div_t;
  logic [TB+1:0]                      div_d1;
  logic [TB+1:0]                      div_d2;
  logic [TB+1:0]                      div_r;
  logic [1:0]                         div_k;

  khi_ram #(
    .Width (khi_pkg::EntryBits),
    .Depth (khi_pkg::MaxBp)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[khi_pkg::AddrBits-1:0]),
    .wdata_i ({cmd_i.key, cmd_i.chr}),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign cur_key     = ram_rdata[khi_pkg::EntryBits-1:IB];
  assign cur_chr     = ram_rdata[IB-1:0];
  assign cmd_ready_o = (state_q == S_IDLE);
  assign cmd_fire    = cmd_valid_i && cmd_ready_o;
  assign hit         = (pos_q >= prev_key_q) && (pos_q < cur_key);

  assign result_o.valid     = out_valid_q;
  assign result_o.lit_count = out_data_q;
  assign stat_o.busy        = (state_q != S_IDLE);
  assign stat_o.bp_count    = count_q;

  // one quotient bit per cycle; remainder stays below 3*d so at most two subtracts
  always_comb begin
    div_t  = {1'b0, rem_q, 1'b0} + (c_q[bit_q] ? {2'b00, n_q} : '0);
    div_d1 = {2'b00, d_q};
    div_d2 = {1'b0, d_q, 1'b0};
    if (div_t >= div_d2) begin
      div_r = div_t - div_d2;
      div_k = 2'd2;
    end else if (div_t >= div_d1) begin
      div_r = div_t - div_d1;
      div_k = 2'd1;
    end else begin
      div_r = div_t;
      div_k = 2'd0;
    end
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    bit_d       = bit_q;
    pos_d       = pos_q;
    prev_key_d  = prev_key_q;
    prev_chr_d  = prev_chr_q;
    c_d         = c_q;
    n_d         = n_q;
    d_d         = d_q;
    si_d        = si_q;
    quo_d       = quo_q;
    rem_d       = rem_q;
    res_d       = res_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q && !result_o.ready;
    ram_we      = 1'b0;
    ram_raddr   = '0;

    unique case (state_q)
      S_IDLE: begin
        if (cmd_fire) begin
          case (cmd_i.op)
            khi_pkg::OP_APPEND: begin
              if (count_q < khi_pkg::CountBits'(khi_pkg::MaxBp)) begin
                ram_we  = 1'b1;
                count_d = count_q + 1'b1;
              end
            end
            khi_pkg::OP_CLEAR: begin
              count_d = '0;
            end
            khi_pkg::OP_QUERY: begin
              pos_d = cmd_i.key;
              idx_d = '0;
              // fewer than two breakpoints means no interval at all
              if (!timing_en_i || count_q < khi_pkg::CountBits'(2)) begin
                res_d   = text_len_i;
                state_d = S_EMIT;
              end else begin
                state_d = S_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_SCAN: begin
        ram_raddr = idx_q + 1'b1;
        if (idx_q == '0) begin
          prev_key_d = cur_key;
          prev_chr_d = cur_chr;
          idx_d      = idx_q + 1'b1;
        end else if (hit) begin
          if (cur_chr <= prev_chr_q) begin
            res_d   = prev_chr_q;
            state_d = S_EMIT;
          end else begin
            c_d     = cur_chr - prev_chr_q;
            n_d     = pos_q - prev_key_q;
            d_d     = cur_key - prev_key_q;
            si_d    = prev_chr_q;
            quo_d   = '0;
            rem_d   = '0;
            bit_d   = khi_pkg::BitCntBits'(IB - 1);
            state_d = S_DIV;
          end
        end else if ({1'b0, idx_q} == count_q - 1'b1) begin
          res_d   = text_len_i;
          state_d = S_EMIT;
        end else begin
          prev_key_d = cur_key;
          prev_chr_d = cur_chr;
          idx_d      = idx_q + 1'b1;
        end
      end

      S_DIV: begin
        quo_d = {quo_q[IB-2:0], 1'b0} + IB'(div_k);
        rem_d = div_r[TB-1:0];
        if (bit_q == '0) begin
          state_d = S_SUM;
        end else begin
          bit_d = bit_q - 1'b1;
        end
      end

      S_SUM: begin
        // ceiling: round up on a nonzero remainder
        res_d   = si_q + quo_q + IB'(rem_q != '0);
        state_d = S_EMIT;
      end

      S_EMIT: begin
        if (!out_valid_q || result_o.ready) begin
          out_valid_d = 1'b1;
          out_data_d  = res_q;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      bit_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      bit_q       <= bit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q      <= pos_d;
    prev_key_q <= prev_key_d;
    prev_chr_q <= prev_chr_d;
    c_q        <= c_d;
    n_q        <= n_d;
    d_q        <= d_d;
    si_q       <= si_d;
    quo_q      <= quo_d;
    rem_q      <= rem_d;
    res_q      <= res_d;
    out_data_q <= out_data_d;
  end

endmodule

`default_nettype wire

// ===== rtl/karaoke_highlight_interpolator.sv =====
// Highlight position for a karaoke lyric line, from a stored table of up to
// 64 breakpoints (time, character index). Appends and clears take effect as
// they leave the two-word command queue. When timing is off or fewer than
// two breakpoints are stored, a query skips the scan and the division;
// otherwise the breakpoint pairs are scanned one per cycle from the single read
// port of the store, followed by a shift-subtract ceiling division and a final
// add. The front queue keeps taking words while a query is in progress or a
// result waits to be taken, as long as its two entries are not full.
// Depends on khi_pkg, khi_if, khi_ram, khi_front and khi_back.
`timescale 1ns / 1ps
`default_nettype none

module karaoke_highlight_interpolator (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  khi_in_if.sink                                 item_i,
  khi_out_if.source                              result_o,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [khi_pkg::ApbAddrBits-1:0]   paddr,
  input  wire logic [khi_pkg::ApbDataBits-1:0]   pwdata,
  output logic      [khi_pkg::ApbDataBits-1:0]   prdata,
  output logic                                   pready
);

  logic                              timing_en_q, timing_en_d;
  logic [khi_pkg::IndexBits-1:0]     text_len_q, text_len_d;
  logic                              cfg_wr;
  khi_pkg::khi_cmd_t                 cmd;
  logic                              cmd_valid;
  logic                              cmd_ready;
  khi_pkg::khi_stat_t                stat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    timing_en_d = timing_en_q;
    text_len_d  = text_len_q;
    if (cfg_wr) begin
      unique case (paddr[2])
        khi_pkg::RegTiming:  timing_en_d = pwdata[0];
        khi_pkg::RegTextLen: text_len_d  = pwdata[khi_pkg::IndexBits-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      khi_pkg::RegTiming:  prdata = khi_pkg::ApbDataBits'(timing_en_q);
      khi_pkg::RegTextLen: prdata = khi_pkg::ApbDataBits'(text_len_q);
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timing_en_q <= 1'b0;
      text_len_q  <= '0;
    end else begin
      timing_en_q <= timing_en_d;
      text_len_q  <= text_len_d;
    end
  end

  khi_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item_i),
    .cmd_o       (cmd),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready)
  );

  khi_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .timing_en_i (timing_en_q),
    .text_len_i  (text_len_q),
    .result_o    (result_o),
    .stat_o      (stat)
  );

  // a clear empties the table on the next cycle
  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_valid && cmd_ready && cmd.op == khi_pkg::OP_CLEAR) |=> (stat.bp_count == '0))
    else $error("breakpoint count not zero after clear");

  // an append below capacity grows the table by exactly one
  a_append_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_valid && cmd_ready && cmd.op == khi_pkg::OP_APPEND &&
     stat.bp_count < khi_pkg::CountBits'(khi_pkg::MaxBp))
    |=> (stat.bp_count == $past(stat.bp_count) + 1'b1))
    else $error("append did not add one breakpoint");

  // a new result only comes out of a query in progress
  a_result_from_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(result_o.valid) |-> $past(stat.busy))
    else $error("result raised while back end was idle");

endmodule

`default_nettype wire
